// ----- src/lzgbd_pkg.sv -----
// Shared types and constants for the LZ gamma bit-flag decompressor.
`default_nettype none
package lzgbd_pkg;

	localparam int WINDOW_DEPTH = 8192;
	localparam int ADDR_W = $clog2(WINDOW_DEPTH);
	localparam int MAX_COPY = 64;

	typedef enum logic [3:0] {
		PH_HEADER,
		PH_TOKEN,
		PH_KIND,
		PH_LONGBITS,
		PH_GCONT,
		PH_GVAL,
		PH_LITERAL,
		PH_SHORTD,
		PH_LONGD,
		PH_ENDED,
		PH_FAILED
	} phase_t;

	typedef enum logic [1:0] {
		E_IDLE,
		E_BITS,
		E_CRD,
		E_CWR
	} eng_t;

	typedef struct packed {
		logic restart;
		logic hdr;
		logic load_flag;
		logic step_bit;
		logic set_dist_short;
		logic set_dist_long;
		logic shift_dist;
		logic gval;
		logic start_copy;
		logic copy_rd;
		logic copy_wr;
		logic put_lit;
		logic emit;
		logic emit_end;
		logic emit_bad;
		logic emit_last;
	} cmd_t;

	typedef struct packed {
		logic bit_val;
		logic mask_zero;
		logic hdr_done;
		logic byte_zero;
		logic dist_final;
		logic too_long;
		logic copy_last;
		logic out_busy;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// ----- src/lzgbd_ctrl.sv -----
// Controller: parse phase and engine sequencing.
`default_nettype none
module lzgbd_ctrl
	import lzgbd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	input  wire logic  s_tuser,
	output logic       s_tready,
	input  wire stat_t st,
	output cmd_t       cmd
);

	eng_t   eng_q, eng_d;
	phase_t phase_q, phase_d;
	phase_t eff_ph;
	logic   in_bits_phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_q   <= E_IDLE;
			phase_q <= PH_HEADER;
		end else begin
			eng_q   <= eng_d;
			phase_q <= phase_d;
		end
	end

	assign in_bits_phase = (phase_q == PH_TOKEN) || (phase_q == PH_KIND) ||
		(phase_q == PH_LONGBITS) || (phase_q == PH_GCONT) || (phase_q == PH_GVAL);

	always_comb begin
		cmd      = '0;
		eng_d    = eng_q;
		phase_d  = phase_q;
		s_tready = 1'b0;
		eff_ph   = s_tuser ? PH_HEADER : phase_q;
		case (eng_q)
			E_IDLE: begin
				s_tready = !st.out_busy;
				if (s_tvalid && !st.out_busy) begin
					cmd.restart = s_tuser;
					phase_d = eff_ph;
					case (eff_ph)
						PH_HEADER: begin
							cmd.hdr = 1'b1;
							if (st.hdr_done)
								phase_d = PH_TOKEN;
						end
						PH_TOKEN, PH_KIND, PH_LONGBITS, PH_GCONT, PH_GVAL: begin
							cmd.load_flag = 1'b1;
							eng_d = E_BITS;
						end
						PH_LITERAL: begin
							cmd.put_lit   = 1'b1;
							cmd.emit      = 1'b1;
							cmd.emit_last = 1'b1;
							phase_d = PH_TOKEN;
							eng_d   = E_BITS;
						end
						PH_SHORTD: begin
							if (st.byte_zero) begin
								cmd.emit      = 1'b1;
								cmd.emit_end  = 1'b1;
								cmd.emit_last = 1'b1;
								phase_d = PH_ENDED;
							end else begin
								cmd.set_dist_short = 1'b1;
								phase_d = PH_GCONT;
								eng_d   = E_BITS;
							end
						end
						PH_LONGD: begin
							cmd.set_dist_long = 1'b1;
							phase_d = PH_LONGBITS;
							eng_d   = E_BITS;
						end
						default: begin
							cmd.emit      = 1'b1;
							cmd.emit_bad  = 1'b1;
							cmd.emit_last = 1'b1;
						end
					endcase
				end
			end
			E_BITS: begin
				if (st.mask_zero || !in_bits_phase) begin
					eng_d = E_IDLE;
				end else if (st.out_free) begin
					cmd.step_bit = 1'b1;
					case (phase_q)
						PH_TOKEN: phase_d = st.bit_val ? PH_KIND : PH_LITERAL;
						PH_KIND:  phase_d = st.bit_val ? PH_LONGD : PH_SHORTD;
						PH_LONGBITS: begin
							cmd.shift_dist = 1'b1;
							if (st.dist_final)
								phase_d = PH_GCONT;
						end
						PH_GCONT: begin
							if (st.bit_val) begin
								phase_d = PH_GVAL;
							end else if (st.too_long) begin
								cmd.emit      = 1'b1;
								cmd.emit_bad  = 1'b1;
								cmd.emit_last = 1'b1;
								phase_d = PH_FAILED;
							end else begin
								cmd.start_copy = 1'b1;
								phase_d = PH_TOKEN;
								eng_d   = E_CRD;
							end
						end
						PH_GVAL: begin
							cmd.gval = 1'b1;
							phase_d  = PH_GCONT;
						end
						default: ;
					endcase
				end
			end
			E_CRD: begin
				cmd.copy_rd = 1'b1;
				eng_d = E_CWR;
			end
			E_CWR: begin
				if (st.out_free) begin
					cmd.copy_wr   = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_last = st.copy_last;
					eng_d = st.copy_last ? E_BITS : E_CRD;
				end
			end
			default: eng_d = E_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ----- src/lzgbd_dp.sv -----
// Datapath: header, flag bits, distance and length registers, history, result register.
`default_nettype none
module lzgbd_dp
	import lzgbd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  in_byte,
	input  wire cmd_t        cmd,
	output stat_t            st,
	input  wire logic        m_tready,
	output logic             out_valid,
	output logic [7:0]       out_data,
	output logic             out_byte_valid,
	output logic             out_last,
	output logic             out_end,
	output logic             out_bad,
	output logic [23:0]      out_size
);

	logic [7:0]        history [WINDOW_DEPTH];
	logic [ADDR_W-1:0] wp_q;
	logic [1:0]        hcnt_q;
	logic [23:0]       size_q;
	logic [7:0]        flag_q;
	logic [7:0]        mask_q;
	logic [13:0]       dist_q;
	logic [6:0]        len_q;
	logic [2:0]        rem_q;
	logic [6:0]        cnt_q;
	logic [7:0]        rdata_q;
	logic              out_valid_q;

	logic [1:0]        eff_cnt;
	logic [11:0]       new_dist;
	logic [7:0]        len_next;
	logic [7:0]        wdata;
	logic [ADDR_W-1:0] raddr;

	assign eff_cnt  = cmd.restart ? 2'd0 : hcnt_q;
	assign new_dist = {dist_q[10:0], st.bit_val};
	assign len_next = {len_q, st.bit_val};
	assign wdata    = cmd.put_lit ? in_byte : rdata_q;
	assign raddr    = wp_q - ADDR_W'({18'd0, dist_q});

	always_comb begin
		st.bit_val    = |(flag_q & mask_q);
		st.mask_zero  = (mask_q == 8'd0);
		st.hdr_done   = (eff_cnt == 2'd3);
		st.byte_zero  = (in_byte == 8'd0);
		st.dist_final = (rem_q <= 3'd1);
		st.too_long   = ({1'b0, len_q} >= 8'(MAX_COPY));
		st.copy_last  = (cnt_q == 7'd1);
		st.out_busy   = out_valid_q;
		st.out_free   = !out_valid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			hcnt_q <= 2'd0;
			size_q <= 24'd0;
			flag_q <= 8'd0;
			mask_q <= 8'h80;
			dist_q <= 14'd0;
			len_q  <= 7'd1;
			rem_q  <= 3'd0;
			cnt_q  <= 7'd0;
		end else begin
			if (cmd.hdr) begin
				if (eff_cnt != 2'd0)
					size_q <= {size_q[15:0], in_byte};
				else if (cmd.restart)
					size_q <= 24'd0;
				if (st.hdr_done) begin
					hcnt_q <= 2'd0;
					flag_q <= 8'd0;
					mask_q <= 8'd0;
				end else begin
					hcnt_q <= eff_cnt + 2'd1;
				end
			end
			if (cmd.load_flag) begin
				flag_q <= in_byte;
				mask_q <= 8'h80;
			end
			if (cmd.step_bit)
				mask_q <= mask_q >> 1;
			if (cmd.set_dist_short) begin
				dist_q <= 14'd256 - {6'd0, in_byte};
				len_q  <= 7'd1;
			end
			if (cmd.set_dist_long) begin
				dist_q <= {6'd0, in_byte};
				rem_q  <= 3'd4;
			end
			if (cmd.shift_dist) begin
				if (rem_q != 3'd0)
					rem_q <= rem_q - 3'd1;
				if (st.dist_final) begin
					// back offset of a long match
					dist_q <= 14'd4351 - {2'd0, new_dist};
					len_q  <= 7'd1;
				end else begin
					dist_q <= {2'd0, new_dist};
				end
			end
			if (cmd.gval)
				len_q <= (len_next > 8'd127) ? 7'd127 : len_next[6:0];
			if (cmd.start_copy)
				cnt_q <= len_q + 7'd1;
			if (cmd.copy_wr)
				cnt_q <= cnt_q - 7'd1;
			if (cmd.put_lit || cmd.copy_wr)
				wp_q <= wp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put_lit || cmd.copy_wr)
			history[wp_q] <= wdata;
		if (cmd.copy_rd)
			rdata_q <= history[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data       <= (cmd.emit_end || cmd.emit_bad) ? 8'd0 : wdata;
			out_byte_valid <= cmd.put_lit || cmd.copy_wr;
			out_last       <= cmd.emit_last;
			out_end        <= cmd.emit_end;
			out_bad        <= cmd.emit_bad;
			out_size       <= size_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- src/lz_gamma_bitflag_decompressor_unit.sv -----
// Top level of the LZ gamma bit-flag decompressor.
//  channel  dir  tdata                               tuser                         tlast
//  s_*      in   [7:0] in_byte                       start_stream                  -
//  m_*      out  [7:0] data_byte, [31:8] decl. size  [0] byte_valid [1] end [2] bad run_last
// One input item is taken per idle cycle while no result is pending; the bits of a flag
// byte are then stepped one at a time while the result register is free. A match copies
// each byte as a history read, then a write and emit that wait on a stalled result; the
// single-port history sets the copy rate.
// Reset clears the parser; history contents are undefined until written.
// A stalled result stalls the engine; no input is taken while a result is pending.
`default_nettype none
module lz_gamma_bitflag_decompressor_unit
	import lzgbd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tuser,   // [0] start_stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [7:0] data_byte, [31:8] declared_size
	output logic [2:0]       m_tuser,   // [0] byte_valid, [1] stream_end, [2] bad_input
	output logic             m_tlast
);

	cmd_t        cmd;
	stat_t       st;
	logic [7:0]  o_data;
	logic        o_bv;
	logic        o_end;
	logic        o_bad;
	logic [23:0] o_size;

	lzgbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	lzgbd_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_byte        (s_tdata),
		.cmd            (cmd),
		.st             (st),
		.m_tready       (m_tready),
		.out_valid      (m_tvalid),
		.out_data       (o_data),
		.out_byte_valid (o_bv),
		.out_last       (m_tlast),
		.out_end        (o_end),
		.out_bad        (o_bad),
		.out_size       (o_size)
	);

	assign m_tdata = {o_size, o_data};
	assign m_tuser = {o_bad, o_end, o_bv};

endmodule
`default_nettype wire

// ----- src/lzgbd_checker.sv -----
// Port-level checks for the decompressor, bound to the top level.
`default_nettype none
module lzgbd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [2:0]  m_tuser,
	input wire logic        m_tlast
);

	// input side waits while a result is pending
	a_no_take_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken with result pending");

	a_end_bad_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1] || m_tuser[2]) |-> m_tlast)
		else $error("end or error result not last");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tuser[1] && !m_tuser[2])
		else $error("data byte flagged as end or error");

	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
		else $error("nonzero data on non-data result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind lz_gamma_bitflag_decompressor_unit lzgbd_checker u_lzgbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire
